@@ sv/aprm_pkg.sv @@
// Package for the aging page replacement MMU core.
// Holds operation and status codes, register indexes and default sizes.
// No dependencies; the interfaces, the core and the checker use it by scoped names.
package aprm_pkg;

  // Default sizes handed to the top level as parameter defaults.
  localparam int unsigned DefFrames          = 16;
  localparam int unsigned DefAgeBits         = 8;
  localparam int unsigned DefProcesses       = 8;
  localparam int unsigned DefPagesPerProcess = 64;

  // Reset values of the configuration registers.
  localparam logic [8:0] PeriodReset = 9'd4;
  localparam logic [7:0] NewAgeReset = 8'd128;

  // Width of the configuration register index.
  localparam int unsigned CfgIdxW = 8;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] CFG_AGING_PERIOD = 8'd0;
  localparam logic [CfgIdxW-1:0] CFG_NEW_PAGE_AGE = 8'd1;

  // Operation codes of an input beat; OP_UNUSED is dropped without a result.
  typedef enum logic [1:0] {
    OP_READ    = 2'd0,
    OP_WRITE   = 2'd1,
    OP_RELEASE = 2'd2,
    OP_UNUSED  = 2'd3
  } op_e;

  // Status codes of a result beat.
  typedef enum logic [1:0] {
    ST_HIT      = 2'd0,
    ST_FAULT    = 2'd1,
    ST_REPLACE  = 2'd2,
    ST_RELEASED = 2'd3
  } status_e;

endpackage

@@ sv/aprm_if.sv @@
// Channel interfaces of the aging page replacement MMU core.
// Request, result and configuration write channels with valid/ready.
// Depends on aprm_pkg for the configuration index width.
interface aprm_req_if;
  logic       valid;
  logic       ready;
  logic [1:0] op;
  logic [2:0] process_id;
  logic [5:0] page_index;

  modport source (output valid, op, process_id, page_index, input ready);
  modport sink   (input valid, op, process_id, page_index, output ready);
endinterface

interface aprm_rsp_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [4:0]  frame;
  logic [2:0]  evicted_process;
  logic [5:0]  evicted_page;
  logic        writeback;
  logic [4:0]  released_frames;
  logic [4:0]  released_writebacks;
  logic [31:0] access_count;
  logic [31:0] fault_count;

  modport source (output valid, status, frame, evicted_process, evicted_page, writeback,
                  released_frames, released_writebacks, access_count, fault_count,
                  input ready);
  modport sink   (input valid, status, frame, evicted_process, evicted_page, writeback,
                  released_frames, released_writebacks, access_count, fault_count,
                  output ready);
endinterface

interface aprm_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [aprm_pkg::CfgIdxW-1:0] index;
  logic [31:0]                  data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

@@ sv/aprm_ram.sv @@
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module aprm_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem [Depth];

  // Write port and registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

@@ sv/aging_page_replacement_mmu_core.sv @@
// Aging page replacement MMU core. One item is taken at a time. A read or write access
// on a hit or a fault into a free frame passes through its acceptance, a page table read,
// the update and the hand-off to the output register. An aging pass reads and writes back
// the page table entry of each resident page in turn. A replacement first walks the
// resident list once for the victim, then evicts it and loads the new page. A release
// walks the resident list and drops each page of the released process. The page table
// sits in a single memory of one read and one write port; a full resident list holds
// FRAMES pages (16 by default). After reset a clearing pass zeroes all
// PROCESSES*PAGES_PER_PROCESS page table entries (512 by default) before the first item
// is taken; the configuration port takes writes at all times.
// A finished result waits in an output register while the next item is accepted. A
// result that is still waiting there holds the hand-off, and with it the next item.
// Depends on aprm_pkg, aprm_if.sv and aprm_ram.
module aging_page_replacement_mmu_core #(
  parameter int unsigned FRAMES            = aprm_pkg::DefFrames,
  parameter int unsigned AGE_BITS          = aprm_pkg::DefAgeBits,
  parameter int unsigned PROCESSES         = aprm_pkg::DefProcesses,
  parameter int unsigned PAGES_PER_PROCESS = aprm_pkg::DefPagesPerProcess
) (
  input  logic clk_i,
  input  logic rst_ni,
  aprm_req_if.sink   in_if,
  aprm_rsp_if.source out_if,
  aprm_cfg_if.sink   cfg_if
);

  localparam int unsigned PRW   = (PROCESSES > 1) ? $clog2(PROCESSES) : 1;
  localparam int unsigned PGW   = (PAGES_PER_PROCESS > 1) ? $clog2(PAGES_PER_PROCESS) : 1;
  localparam int unsigned DEPTH = PROCESSES * PAGES_PER_PROCESS;
  localparam int unsigned VPW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned FRW   = $clog2(FRAMES + 1);
  localparam int unsigned IDXW  = (FRAMES > 1) ? $clog2(FRAMES) : 1;
  localparam int unsigned CNTW  = $clog2(FRAMES + 1);
  localparam int unsigned PTEW  = 3 + FRW;

  typedef struct packed {
    logic           present;
    logic           referenced;
    logic           dirty;
    logic [FRW-1:0] frame;
  } pte_t;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_AGE_RD, S_AGE_WR, S_LOOK_RD, S_LOOK_EV, S_MIN,
    S_EVICT_RD, S_EVICT_WR, S_LOAD, S_REL_CHK, S_REL_WR, S_DONE
  } state_e;

  state_e state_q;

  // Configuration registers.
  logic [8:0] period_q;
  logic [7:0] new_age_q;

  // Item being worked on.
  logic           wr_q;
  logic [PRW-1:0] proc_q;
  logic [PGW-1:0] page_q;

  // Resident list, kept in load order.
  logic [PRW-1:0]      own_proc_q [FRAMES];
  logic [PGW-1:0]      own_page_q [FRAMES];
  logic [FRW-1:0]      res_frame_q [FRAMES];
  logic [AGE_BITS-1:0] res_age_q [FRAMES];
  logic [CNTW-1:0]     count_q;
  logic [FRAMES-1:0]   free_q;

  // Walk and search state.
  logic [CNTW-1:0]     idx_q;
  logic [IDXW-1:0]     best_q;
  logic [AGE_BITS-1:0] best_age_q;
  logic [VPW-1:0]      clr_q;

  // Counters.
  logic [7:0]  tick_q;
  logic [31:0] acc_q;
  logic [31:0] flt_q;

  // Result being built.
  logic [1:0]      status_q;
  logic [FRW-1:0]  frame_q;
  logic [PRW-1:0]  evp_q;
  logic [PGW-1:0]  evpg_q;
  logic            wb_q;
  logic [CNTW-1:0] relf_q;
  logic [CNTW-1:0] relwb_q;

  // Output register.
  logic        out_valid_q;
  logic [1:0]  o_status_q;
  logic [4:0]  o_frame_q;
  logic [2:0]  o_evp_q;
  logic [5:0]  o_evpg_q;
  logic        o_wb_q;
  logic [4:0]  o_relf_q;
  logic [4:0]  o_relwb_q;
  logic [31:0] o_acc_q;
  logic [31:0] o_flt_q;

  // Page table memory ports.
  logic           pt_we;
  logic [VPW-1:0] pt_waddr;
  logic [VPW-1:0] pt_raddr;
  pte_t           pt_wdata;
  pte_t           pt_rdata;
  logic [PTEW-1:0] pt_rdata_raw;

  aprm_ram #(
    .Width (PTEW),
    .Depth (DEPTH)
  ) u_pt_ram (
    .clk_i   (clk_i),
    .we_i    (pt_we),
    .waddr_i (pt_waddr),
    .wdata_i (pt_wdata),
    .raddr_i (pt_raddr),
    .rdata_o (pt_rdata_raw)
  );

  assign pt_rdata = pte_t'(pt_rdata_raw);

  // Reduction tables that bring out-of-range process and page numbers into range.
  logic [PRW-1:0] proc_mod [8];
  logic [PGW-1:0] page_mod [64];

  for (genvar g = 0; g < 8; g++) begin : g_proc_mod
    assign proc_mod[g] = PRW'(g % PROCESSES);
  end
  for (genvar g = 0; g < 64; g++) begin : g_page_mod
    assign page_mod[g] = PGW'(g % PAGES_PER_PROCESS);
  end

  function automatic logic [VPW-1:0] vp_addr(logic [PRW-1:0] p, logic [PGW-1:0] g);
    vp_addr = VPW'(VPW'(p) * VPW'(PAGES_PER_PROCESS)) + VPW'(g);
  endfunction

  logic [IDXW-1:0] idx;
  logic [VPW-1:0]  cur_vp;
  logic [VPW-1:0]  idx_vp;
  logic [VPW-1:0]  best_vp;
  logic [CNTW-1:0] idx_next;
  logic            idx_last;

  assign idx      = idx_q[IDXW-1:0];
  assign cur_vp   = vp_addr(proc_q, page_q);
  assign idx_vp   = vp_addr(own_proc_q[idx], own_page_q[idx]);
  assign best_vp  = vp_addr(own_proc_q[best_q], own_page_q[best_q]);
  assign idx_next = idx_q + CNTW'(1);
  assign idx_last = (idx_next == count_q);

  // Lowest free frame.
  logic           free_any;
  logic [FRW-1:0] free_frame;

  always_comb begin
    free_frame = '0;
    for (int i = FRAMES - 1; i >= 0; i--) begin
      if (free_q[i]) begin
        free_frame = FRW'(i + 1);
      end
    end
  end
  assign free_any = |free_q;

  // Period clamped to its legal range, and the next tick.
  logic [8:0] period;
  logic [8:0] tick_inc;

  always_comb begin
    period = period_q;
    if (period_q < 9'd2) begin
      period = 9'd2;
    end else if (period_q > 9'd256) begin
      period = 9'd256;
    end
  end
  assign tick_inc = {1'b0, tick_q} + 9'd1;

  // Page table read address.
  always_comb begin
    case (state_q)
      S_LOOK_RD:  pt_raddr = cur_vp;
      S_EVICT_RD: pt_raddr = best_vp;
      default:    pt_raddr = idx_vp;
    endcase
  end

  // Page table writes.
  always_comb begin
    pt_we    = 1'b0;
    pt_waddr = idx_vp;
    pt_wdata = '0;
    case (state_q)
      S_CLEAR: begin
        pt_we    = 1'b1;
        pt_waddr = clr_q;
      end
      S_AGE_WR: begin
        pt_we               = 1'b1;
        pt_wdata            = pt_rdata;
        pt_wdata.referenced = 1'b0;
      end
      S_LOOK_EV: begin
        pt_waddr = cur_vp;
        if (pt_rdata.present) begin
          pt_we               = 1'b1;
          pt_wdata            = pt_rdata;
          pt_wdata.referenced = 1'b1;
          pt_wdata.dirty      = pt_rdata.dirty | wr_q;
        end else if (free_any || count_q == '0) begin
          pt_we    = 1'b1;
          pt_wdata = '{present: 1'b1, referenced: 1'b0, dirty: wr_q, frame: free_frame};
        end
      end
      S_EVICT_WR: begin
        pt_we    = 1'b1;
        pt_waddr = best_vp;
      end
      S_LOAD: begin
        pt_we    = 1'b1;
        pt_waddr = cur_vp;
        pt_wdata = '{present: 1'b1, referenced: 1'b0, dirty: wr_q, frame: frame_q};
      end
      S_REL_WR: begin
        pt_we = 1'b1;
      end
      default: begin
        pt_we = 1'b0;
      end
    endcase
  end

  // Channel handshakes.
  assign in_if.ready  = (state_q == S_IDLE);
  assign cfg_if.ready = 1'b1;

  assign out_if.valid               = out_valid_q;
  assign out_if.status              = o_status_q;
  assign out_if.frame               = o_frame_q;
  assign out_if.evicted_process     = o_evp_q;
  assign out_if.evicted_page        = o_evpg_q;
  assign out_if.writeback           = o_wb_q;
  assign out_if.released_frames     = o_relf_q;
  assign out_if.released_writebacks = o_relwb_q;
  assign out_if.access_count        = o_acc_q;
  assign out_if.fault_count         = o_flt_q;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period_q  <= aprm_pkg::PeriodReset;
      new_age_q <= aprm_pkg::NewAgeReset;
    end else if (cfg_if.valid) begin
      if (cfg_if.index == aprm_pkg::CFG_AGING_PERIOD) begin
        period_q <= cfg_if.data[8:0];
      end else if (cfg_if.index == aprm_pkg::CFG_NEW_PAGE_AGE) begin
        new_age_q <= cfg_if.data[7:0];
      end
    end
  end

  // Sequencer with the resident list, counters and output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_q       <= '0;
      count_q     <= '0;
      free_q      <= '1;
      tick_q      <= '0;
      acc_q       <= '0;
      flt_q       <= '0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      // A taken result empties the output register unless a new one moves in.
      if (out_valid_q && out_if.ready && state_q != S_DONE) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_CLEAR: begin
          clr_q <= clr_q + VPW'(1);
          if (clr_q == VPW'(DEPTH - 1)) begin
            state_q <= S_IDLE;
          end
        end

        S_IDLE: begin
          if (in_if.valid) begin
            wr_q     <= (in_if.op == aprm_pkg::OP_WRITE);
            proc_q   <= proc_mod[in_if.process_id];
            page_q   <= page_mod[in_if.page_index];
            status_q <= aprm_pkg::ST_HIT;
            frame_q  <= '0;
            evp_q    <= '0;
            evpg_q   <= '0;
            wb_q     <= 1'b0;
            relf_q   <= '0;
            relwb_q  <= '0;
            idx_q    <= '0;
            case (in_if.op)
              aprm_pkg::OP_RELEASE: begin
                state_q <= S_REL_CHK;
              end
              aprm_pkg::OP_READ, aprm_pkg::OP_WRITE: begin
                tick_q <= (tick_inc >= period) ? 8'd0 : tick_inc[7:0];
                if (acc_q != '1) begin
                  acc_q <= acc_q + 32'd1;
                end
                if (tick_q == 8'd1 && count_q != '0) begin
                  state_q <= S_AGE_RD;
                end else begin
                  state_q <= S_LOOK_RD;
                end
              end
              default: begin
                state_q <= S_IDLE;
              end
            endcase
          end
        end

        // Aging pass: one resident page per read and write pair.
        S_AGE_RD: begin
          state_q <= S_AGE_WR;
        end
        S_AGE_WR: begin
          res_age_q[idx] <= {pt_rdata.referenced, res_age_q[idx][AGE_BITS-1:1]};
          if (idx_last) begin
            state_q <= S_LOOK_RD;
          end else begin
            idx_q   <= idx_next;
            state_q <= S_AGE_RD;
          end
        end

        // Page table lookup of the accessed page.
        S_LOOK_RD: begin
          state_q <= S_LOOK_EV;
        end
        S_LOOK_EV: begin
          if (pt_rdata.present) begin
            frame_q <= pt_rdata.frame;
            state_q <= S_DONE;
          end else begin
            if (flt_q != '1) begin
              flt_q <= flt_q + 32'd1;
            end
            if (free_any || count_q == '0) begin
              status_q <= aprm_pkg::ST_FAULT;
              frame_q  <= free_frame;
              if (free_any) begin
                free_q[IDXW'(free_frame - FRW'(1))] <= 1'b0;
              end
              if (count_q < CNTW'(FRAMES)) begin
                own_proc_q[count_q[IDXW-1:0]]  <= proc_q;
                own_page_q[count_q[IDXW-1:0]]  <= page_q;
                res_frame_q[count_q[IDXW-1:0]] <= free_frame;
                res_age_q[count_q[IDXW-1:0]]   <= AGE_BITS'(new_age_q);
                count_q                        <= count_q + CNTW'(1);
              end
              state_q <= S_DONE;
            end else begin
              idx_q      <= '0;
              best_q     <= '0;
              best_age_q <= '1;
              state_q    <= S_MIN;
            end
          end
        end

        // First resident page of minimal age.
        S_MIN: begin
          if (res_age_q[idx] < best_age_q) begin
            best_q     <= idx;
            best_age_q <= res_age_q[idx];
          end
          if (idx_last) begin
            state_q <= S_EVICT_RD;
          end else begin
            idx_q <= idx_next;
          end
        end

        // Evict the victim; its frame goes straight to the new page.
        S_EVICT_RD: begin
          status_q <= aprm_pkg::ST_REPLACE;
          frame_q  <= res_frame_q[best_q];
          evp_q    <= own_proc_q[best_q];
          evpg_q   <= own_page_q[best_q];
          state_q  <= S_EVICT_WR;
        end
        S_EVICT_WR: begin
          wb_q <= pt_rdata.dirty;
          for (int j = 0; j < FRAMES - 1; j++) begin
            if (j >= int'(best_q)) begin
              own_proc_q[j]  <= own_proc_q[j+1];
              own_page_q[j]  <= own_page_q[j+1];
              res_frame_q[j] <= res_frame_q[j+1];
              res_age_q[j]   <= res_age_q[j+1];
            end
          end
          count_q <= count_q - CNTW'(1);
          state_q <= S_LOAD;
        end
        S_LOAD: begin
          own_proc_q[count_q[IDXW-1:0]]  <= proc_q;
          own_page_q[count_q[IDXW-1:0]]  <= page_q;
          res_frame_q[count_q[IDXW-1:0]] <= frame_q;
          res_age_q[count_q[IDXW-1:0]]   <= AGE_BITS'(new_age_q);
          count_q                        <= count_q + CNTW'(1);
          state_q                        <= S_DONE;
        end

        // Release: walk the resident list and drop the process's pages.
        S_REL_CHK: begin
          if (idx_q == count_q) begin
            status_q <= aprm_pkg::ST_RELEASED;
            state_q  <= S_DONE;
          end else if (own_proc_q[idx] == proc_q) begin
            state_q <= S_REL_WR;
          end else begin
            idx_q <= idx_next;
          end
        end
        S_REL_WR: begin
          relf_q  <= relf_q + CNTW'(1);
          relwb_q <= relwb_q + CNTW'(pt_rdata.dirty);
          if (res_frame_q[idx] != '0) begin
            free_q[IDXW'(res_frame_q[idx] - FRW'(1))] <= 1'b1;
          end
          for (int j = 0; j < FRAMES - 1; j++) begin
            if (j >= int'(idx)) begin
              own_proc_q[j]  <= own_proc_q[j+1];
              own_page_q[j]  <= own_page_q[j+1];
              res_frame_q[j] <= res_frame_q[j+1];
              res_age_q[j]   <= res_age_q[j+1];
            end
          end
          count_q <= count_q - CNTW'(1);
          state_q <= S_REL_CHK;
        end

        // Hand the result to the output register once it is free.
        S_DONE: begin
          if (!out_valid_q || out_if.ready) begin
            out_valid_q <= 1'b1;
            o_status_q  <= status_q;
            o_frame_q   <= 5'(frame_q);
            o_evp_q     <= 3'(evp_q);
            o_evpg_q    <= 6'(evpg_q);
            o_wb_q      <= wb_q;
            o_relf_q    <= 5'(relf_q);
            o_relwb_q   <= 5'(relwb_q);
            o_acc_q     <= acc_q;
            o_flt_q     <= flt_q;
            state_q     <= S_IDLE;
          end
        end

        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

endmodule

@@ sv/aprm_checker.sv @@
// Port-level checks for the aging page replacement MMU core, and their bind.
// Depends on aprm_pkg and on the top level aging_page_replacement_mmu_core.
module aprm_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic [1:0] status_i,
  input logic [4:0] frame_i,
  input logic       writeback_i
);

  // A result beat that is not taken stays offered.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result beat dropped before it was taken");

  // No result beat while reset is applied or right after it.
  a_reset_quiet: assert property (@(posedge clk_i)
    !rst_ni |=> !out_valid_i)
    else $error("result beat shown during reset");

  // A release reports no frame and no writeback.
  a_release_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && status_i == aprm_pkg::ST_RELEASED |-> frame_i == 5'd0 && !writeback_i)
    else $error("release beat carries frame or writeback");

  // An access always names a frame.
  a_access_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && status_i != aprm_pkg::ST_RELEASED |-> frame_i != 5'd0)
    else $error("access beat without a frame");

endmodule

bind aging_page_replacement_mmu_core aprm_checker u_aprm_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_i (out_if.valid),
  .out_ready_i (out_if.ready),
  .status_i    (out_if.status),
  .frame_i     (out_if.frame),
  .writeback_i (out_if.writeback)
);
